// File: rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the frustum cull test block.
// ----------------------------------------------------------------------------
package fct_pkg;

   // planes in register order: right, left, top, bottom, far, near
   localparam int REG_COUNT   = 6;
   localparam int PLANE_COUNT = 6;
   localparam int ACTIVE_PLANES = (PLANE_COUNT > REG_COUNT) ? REG_COUNT :
                                  (PLANE_COUNT < 0) ? 0 : PLANE_COUNT;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam int COORD_W = 16;
   localparam int RADIUS_W = 15;
   localparam int FRAC_SHIFT = 14;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int SUM_W   = PROD_W + 3;

   localparam logic CMD_SPHERE = 1'b0;
   localparam logic CMD_BOX    = 1'b1;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [CSR_DATA_W-1:0]      plane_type;
   typedef logic [REG_COUNT-1:0][CSR_DATA_W-1:0] plane_array_type;

   typedef struct packed {
      logic                cmd;
      coord_type           lo_x;
      coord_type           lo_y;
      coord_type           lo_z;
      coord_type           hi_x;
      coord_type           hi_y;
      coord_type           hi_z;
      logic [RADIUS_W-1:0] radius;
   } item_type;

endpackage

// File: rtl/frustum_cull_test_core.sv
// ----------------------------------------------------------------------------
// frustum_cull_test_core
// View frustum culling of spheres, points and axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//  - software loads the six planes over the APB-style port (8-byte stride,
//    right, left, top, bottom, far, near); each packs nx, ny, nz in Q1.14
//    and offset in Q11.4, 16 bits apiece from bit 0 up
//  - an object is transferred when start is high and busy is low; busy is
//    only high during reset, so one object can be issued every cycle
//  - req_command low tests a sphere (radius 0 is a point), high a box
//    spanned by the first (min) and second (max) coordinates
//  - one result per object: rsp_valid pulses for one cycle with
//    rsp_visible, in issue order
//  - throughput one object per cycle; latency is set by the input register,
//    the multiplier stage, the corner pick, the sum and the result register
//  - the receiver cannot stall; results are not held
//  - reset clears the planes to zero and drops every object in flight
// ----------------------------------------------------------------------------
module frustum_cull_test_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_command,
   input  logic signed [15:0]               req_first_x,
   input  logic signed [15:0]               req_first_y,
   input  logic signed [15:0]               req_first_z,
   input  logic signed [15:0]               req_second_x,
   input  logic signed [15:0]               req_second_y,
   input  logic signed [15:0]               req_second_z,
   input  logic [14:0]                      req_sphere_radius,
   output logic                             rsp_valid,
   output logic                             rsp_visible,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fct_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fct_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import fct_pkg::*;

   plane_array_type        planes;
   item_type               item_ff, item_in;
   logic [3:0]             v_ff, v_in;
   logic [REG_COUNT-1:0]   pass;
   logic                   accept;
   logic                   rsp_valid_ff, rsp_visible_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   fct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .planes  (planes)
   );

   always_comb begin
      item_in.cmd    = req_command;
      item_in.lo_x   = req_first_x;
      item_in.lo_y   = req_first_y;
      item_in.lo_z   = req_first_z;
      item_in.hi_x   = req_second_x;
      item_in.hi_y   = req_second_y;
      item_in.hi_z   = req_second_z;
      item_in.radius = req_sphere_radius;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   // valid bits travel alongside the plane unit stages
   assign v_in = {v_ff[2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   for (genvar p = 0; p < REG_COUNT; p++) begin : g_plane
      if (p < ACTIVE_PLANES) begin : g_on
         fct_plane_unit u_plane (
            .clock (clock),
            .plane (planes[p]),
            .item  (item_ff),
            .pass  (pass[p])
         );
      end else begin : g_off
         assign pass[p] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         rsp_visible_ff <= 1'b0;
      end else begin
         rsp_valid_ff   <= v_ff[3];
         rsp_visible_ff <= v_ff[3] && (&pass);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted object produced no result");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result without a matching transfer");

   a_visible_only_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_visible |-> rsp_valid)
      else $error("visible flag outside a result cycle");

endmodule

// File: rtl/fct_csr.sv
// ----------------------------------------------------------------------------
// fct_csr
// Plane register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module fct_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fct_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [fct_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [fct_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output fct_pkg::plane_array_type            planes
);
   import fct_pkg::*;

   plane_array_type        plane_ff;
   plane_array_type        plane_in;
   logic [CSR_IDX_W-1:0]   idx;
   logic                   wr_en;

   assign idx    = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      plane_in = plane_ff;
      // writes beyond the last plane are dropped
      if (wr_en && (int'(idx) < REG_COUNT)) begin
         plane_in[idx] = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   always_comb begin
      if (int'(idx) < REG_COUNT) begin
         prdata = plane_ff[idx];
      end else begin
         prdata = '0;
      end
   end

   assign planes = plane_ff;

endmodule

// File: rtl/fct_plane_unit.sv
// ----------------------------------------------------------------------------
// fct_plane_unit
// Three-stage test of one object against one plane: products, per-axis
// corner pick, sum and sign.
// ----------------------------------------------------------------------------
module fct_plane_unit (
   input  logic                clock,
   input  fct_pkg::plane_type  plane,
   input  fct_pkg::item_type   item,
   output logic                pass
);
   import fct_pkg::*;

   coord_type  nx, ny, nz, ofs;

   prod_type   plo_in [3];
   prod_type   phi_in [3];
   prod_type   plo_ff [3];
   prod_type   phi_ff [3];
   sum_type    base_in, base1_ff, base2_ff;
   logic       cmd1_ff;

   prod_type   term_in [3];
   prod_type   term_ff [3];

   sum_type    sum_in;
   logic       pass_ff, pass_in;

   assign nx  = coord_type'(plane[15:0]);
   assign ny  = coord_type'(plane[31:16]);
   assign nz  = coord_type'(plane[47:32]);
   assign ofs = coord_type'(plane[63:48]);

   // stage 1: products of the normal with both coordinate sets
   always_comb begin
      plo_in[0] = item.lo_x * nx;
      plo_in[1] = item.lo_y * ny;
      plo_in[2] = item.lo_z * nz;
      phi_in[0] = item.hi_x * nx;
      phi_in[1] = item.hi_y * ny;
      phi_in[2] = item.hi_z * nz;
      // offset and, for a sphere, radius moved to the Q.18 grid
      base_in = {{(SUM_W-COORD_W-FRAC_SHIFT){ofs[COORD_W-1]}}, ofs, {FRAC_SHIFT{1'b0}}}
              + ((item.cmd == CMD_BOX) ? sum_type'(0)
                 : {{(SUM_W-RADIUS_W-FRAC_SHIFT){1'b0}}, item.radius, {FRAC_SHIFT{1'b0}}});
   end

   always_ff @(posedge clock) begin
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      base1_ff <= base_in;
      cmd1_ff  <= item.cmd;
   end

   // stage 2: best corner of a box is the larger product on every axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         term_in[i] = ((cmd1_ff == CMD_BOX) && (phi_ff[i] > plo_ff[i])) ? phi_ff[i]
                                                                        : plo_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      term_ff  <= term_in;
      base2_ff <= base1_ff;
   end

   // stage 3: sum and sign
   always_comb begin
      sum_in  = sum_type'(term_ff[0]) + sum_type'(term_ff[1]) + sum_type'(term_ff[2])
              + base2_ff;
      pass_in = (sum_in > 0);
   end

   always_ff @(posedge clock) begin
      pass_ff <= pass_in;
   end

   assign pass = pass_ff;

endmodule
